>>> hdl/box_blur_5x5_q15_defines.svh
// ---------------------------------------------------------------------------
// box_blur_5x5_q15 assertion macros
// Shared concurrent assertion forms; clk and rst_n come from the using module.
// ---------------------------------------------------------------------------
`ifndef BOX_BLUR_5X5_Q15_DEFINES_SVH
`define BOX_BLUR_5X5_Q15_DEFINES_SVH

// same-cycle implication
`define BBQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bbq_pkg.sv
// ---------------------------------------------------------------------------
// bbq_pkg
// Constants, types and helpers of the 5x5 Q1.15 box blur.
// ---------------------------------------------------------------------------
package bbq_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROWS_KEPT  = 5;
  localparam int TAPS       = 25;
  localparam int CENTER_TAP = 12;
  localparam int Q          = 15;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SLOT_W = 3;
  localparam int LS_DEPTH = ROWS_KEPT * MAX_WIDTH;
  localparam int LS_AW    = $clog2(LS_DEPTH);
  localparam int SUM_W    = 23;
  localparam int CFG_W    = 13;

  localparam logic [10:0] W_EDGE   = 11'd1311;
  localparam logic [10:0] W_CENTER = 11'd1304;
  localparam logic [SUM_W:0] ROUND_ADD = (SUM_W+1)'(1 << (Q - 1));

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_PUSH = 3'b100
  } state_t;

  // row slot of the line ring: v mod 5 via reciprocal, exact for 12-bit v
  function automatic logic [SLOT_W-1:0] mod5(input logic [ROW_W-1:0] v);
    logic [23:0] p;
    logic [9:0]  q5;
    logic [ROW_W-1:0] rem;
    p   = {12'd0, v} * 24'd3277;
    q5  = p[23:14];
    rem = v - ROW_W'({q5, 2'b00} + {2'b00, q5});
    return rem[SLOT_W-1:0];
  endfunction

endpackage

>>> hdl/bbq_in_if.sv
// ---------------------------------------------------------------------------
// bbq_in_if
// Pixel input channel.
// ---------------------------------------------------------------------------
interface bbq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

>>> hdl/bbq_out_if.sv
// ---------------------------------------------------------------------------
// bbq_out_if
// Blurred pixel result channel.
// ---------------------------------------------------------------------------
interface bbq_out_if import bbq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [7:0]       pixel_out;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic             last_of_run;
  logic             end_of_frame;
  modport source (output valid, output pixel_out, output out_col, output out_row,
                  output last_of_run, output end_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input out_col, input out_row,
                  input last_of_run, input end_of_frame, output ready);
endinterface

>>> hdl/bbq_cfg_if.sv
// ---------------------------------------------------------------------------
// bbq_cfg_if
// Register write channel.
// ---------------------------------------------------------------------------
interface bbq_cfg_if import bbq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [0:0]       index;
  logic [CFG_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/bbq_cell.sv
// ---------------------------------------------------------------------------
// bbq_cell
// One tap of the transposed weighted-sum chain.
// ---------------------------------------------------------------------------
module bbq_cell import bbq_pkg::*; (
  input  logic             clk,
  input  logic [7:0]       pix,
  input  logic             is_center,
  input  logic [SUM_W-1:0] sum_in,
  output logic [SUM_W-1:0] sum_out
);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [18:0]      prod;

  always_comb begin
    prod    = {11'd0, pix} * {8'd0, (is_center ? W_CENTER : W_EDGE)};
    sum_nxt = sum_in + SUM_W'(prod);
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign sum_out = sum_r;

endmodule

>>> hdl/bbq_chain.sv
// ---------------------------------------------------------------------------
// bbq_chain
// 25 cells; the pixel is broadcast and partial sums march down the row.
// ---------------------------------------------------------------------------
module bbq_chain import bbq_pkg::*; (
  input  logic             clk,
  input  logic [7:0]       pix,
  output logic [SUM_W-1:0] sum
);

  logic [SUM_W-1:0] link [TAPS+1];

  assign link[0] = '0;

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    bbq_cell u_cell (
      .clk       (clk),
      .pix       (pix),
      .is_center (i == CENTER_TAP),
      .sum_in    (link[i]),
      .sum_out   (link[i+1])
    );
  end

  assign sum = link[TAPS];

endmodule

>>> hdl/box_blur_5x5_q15.sv
// ---------------------------------------------------------------------------
// box_blur_5x5_q15
// 5x5 Q1.15 box blur on a raster stream of 8-bit grey pixels.
// ---------------------------------------------------------------------------
// One pixel is taken per transaction; a pixel that completes no window
// leaves the block idle. For each result its 25 neighbors are read one a
// cycle from the single read port of the five-row line store and fed
// through a chain of 25 multiply-add cells; the rounded sum is pushed into
// the output register once it is free. A row end completes up to three
// results and a frame end up to nine; the next pixel is taken once the last
// result of the current one is in the output register.
`include "box_blur_5x5_q15_defines.svh"

module box_blur_5x5_q15 import bbq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bbq_in_if.sink    in_ch,
  bbq_out_if.source out_ch,
  bbq_cfg_if.sink   cfg_ch
);

  localparam logic [4:0] RD_LAST = 5'(TAPS - 1);
  localparam logic [4:0] RD_DONE = 5'(TAPS + 1);
  localparam logic [2:0] K_MAX   = 3'd4;

  state_t state_r, state_nxt;

  logic [11:0]      cfg_w_r;
  logic [12:0]      cfg_h_r;
  logic [COL_W-1:0] col_cnt_r;
  logic [ROW_W-1:0] row_cnt_r;

  logic [COL_W-1:0] x_r, x0_r, x1_r, wl_r;
  logic [ROW_W-1:0] y_r, y1_r, hl_r;
  logic [2:0]       kx_r, ky_r;
  logic [4:0]       k_r;

  logic [7:0]       pend_px_r;
  logic [COL_W-1:0] pend_col_r;
  logic [ROW_W-1:0] pend_row_r;
  logic             pend_last_r, pend_eof_r;

  logic             out_valid_r;
  logic [7:0]       out_px_r;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_row_r;
  logic             out_last_r, out_eof_r;

  logic [7:0]       store [LS_DEPTH];
  logic [7:0]       rd_q_r;

  // frame geometry
  logic [11:0]      w_eff;
  logic [12:0]      h_eff;
  logic [COL_W-1:0] wl, c, x0, x1;
  logic [ROW_W-1:0] hl, r, y0, y1;
  logic             has_out, in_acc, out_free;
  logic [LS_AW-1:0] wr_addr, rd_addr;
  logic signed [13:0] tx, ty;
  logic [COL_W-1:0] xx;
  logic [ROW_W-1:0] yy;
  logic [SUM_W-1:0] chain_sum;
  logic [SUM_W:0]   rnd;
  logic [8:0]       rq;

  always_comb begin
    w_eff = (cfg_w_r == 12'd0) ? 12'd1 :
            (cfg_w_r > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : cfg_w_r;
    h_eff = (cfg_h_r == 13'd0) ? 13'd1 :
            (cfg_h_r > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : cfg_h_r;
    wl = COL_W'(w_eff - 12'd1);
    hl = ROW_W'(h_eff - 13'd1);
    c  = (col_cnt_r > wl) ? wl : col_cnt_r;
    r  = (row_cnt_r > hl) ? hl : row_cnt_r;
    if (c == wl) begin
      x0 = (c >= COL_W'(2)) ? c - COL_W'(2) : '0;
      x1 = c;
    end else begin
      x0 = c - COL_W'(2);
      x1 = c - COL_W'(2);
    end
    if (r == hl) begin
      y0 = (r >= ROW_W'(2)) ? r - ROW_W'(2) : '0;
      y1 = r;
    end else begin
      y0 = r - ROW_W'(2);
      y1 = r - ROW_W'(2);
    end
    has_out = ((c == wl) || (c >= COL_W'(2))) && ((r == hl) || (r >= ROW_W'(2)));
    wr_addr = {mod5(r), c};
  end

  // neighbor address with clamped borders
  always_comb begin
    tx = $signed({3'b000, x_r}) + $signed({11'd0, kx_r}) - 14'sd2;
    ty = $signed({2'b00, y_r}) + $signed({11'd0, ky_r}) - 14'sd2;
    if (tx < 0)                          xx = '0;
    else if (tx > $signed({3'b000, wl_r})) xx = wl_r;
    else                                 xx = tx[COL_W-1:0];
    if (ty < 0)                          yy = '0;
    else if (ty > $signed({2'b00, hl_r})) yy = hl_r;
    else                                 yy = ty[ROW_W-1:0];
    rd_addr = {mod5(yy), xx};
  end

  always_comb begin
    rnd = {1'b0, chain_sum} + ROUND_ADD;
    rq  = rnd[SUM_W:Q];
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_out    = out_px_r;
  assign out_ch.out_col      = out_col_r;
  assign out_ch.out_row      = out_row_r;
  assign out_ch.last_of_run  = out_last_r;
  assign out_ch.end_of_frame = out_eof_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      store[wr_addr] <= in_ch.pixel_in;
    end
    rd_q_r <= store[rd_addr];
  end

  bbq_chain u_chain (
    .clk (clk),
    .pix (rd_q_r),
    .sum (chain_sum)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && has_out) state_nxt = S_READ;
      S_READ: if (k_r == RD_DONE) state_nxt = S_PUSH;
      S_PUSH: if (out_free) state_nxt = pend_last_r ? S_IDLE : S_READ;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_w_r     <= 12'd640;
      cfg_h_r     <= 13'd480;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_FRAME_WIDTH:  cfg_w_r <= cfg_ch.data[11:0];
          REG_FRAME_HEIGHT: cfg_h_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_acc) begin
        if (c == wl) begin
          col_cnt_r <= '0;
          row_cnt_r <= (r == hl) ? '0 : r + ROW_W'(1);
        end else begin
          col_cnt_r <= c + COL_W'(1);
          row_cnt_r <= r;
        end
      end
      if (state_r == S_PUSH && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)             out_valid_r <= 1'b0;
    end
  end

  // job sequencing datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      x_r  <= x0;
      x0_r <= x0;
      x1_r <= x1;
      y_r  <= y0;
      y1_r <= y1;
      wl_r <= wl;
      hl_r <= hl;
      k_r  <= '0;
      kx_r <= '0;
      ky_r <= '0;
    end
    if (state_r == S_READ) begin
      if (k_r <= RD_LAST) begin
        if (kx_r == K_MAX) begin
          kx_r <= '0;
          ky_r <= ky_r + 3'd1;
        end else begin
          kx_r <= kx_r + 3'd1;
        end
      end
      if (k_r == RD_DONE) begin
        pend_px_r   <= (rq > 9'd255) ? 8'd255 : rq[7:0];
        pend_col_r  <= x_r;
        pend_row_r  <= y_r;
        pend_last_r <= (x_r == x1_r) && (y_r == y1_r);
        pend_eof_r  <= (x_r == wl_r) && (y_r == hl_r);
      end else begin
        k_r <= k_r + 5'd1;
      end
    end
    if (state_r == S_PUSH && out_free) begin
      out_px_r   <= pend_px_r;
      out_col_r  <= pend_col_r;
      out_row_r  <= pend_row_r;
      out_last_r <= pend_last_r;
      out_eof_r  <= pend_eof_r;
      k_r  <= '0;
      kx_r <= '0;
      ky_r <= '0;
      if (x_r == x1_r) begin
        x_r <= x0_r;
        y_r <= y_r + ROW_W'(1);
      end else begin
        x_r <= x_r + COL_W'(1);
      end
    end
  end

  `BBQ_ASSERT_SAME(a_eof_is_last, out_valid_r && out_eof_r, out_last_r, "end of frame not last of run")
  `BBQ_ASSERT_SAME(a_k_range, state_r == S_READ, k_r <= RD_DONE, "read phase counter overran")
  `BBQ_ASSERT_NEXT(a_push_loads, state_r == S_PUSH && out_free, out_valid_r, "push lost a result")
  `BBQ_ASSERT_NEXT(a_busy_blocks, state_r == S_READ, !in_ch.ready, "input taken mid-result")

endmodule
